>>> rtl/core/prc_pkg.sv
// Shared types and fixed widths for the phase-roll diversity combiner.
package prc_pkg;

    // Sample and gain width (Q2.13) and accumulator width (Q13.26).
    localparam int SAMPLE_W = 16;
    localparam int ACC_W    = 40;

    // The combining weight needs two guard bits over a sample.
    localparam int WEIGHT_W = SAMPLE_W + 2;
    localparam int PROD_W   = SAMPLE_W + WEIGHT_W;
    // One complex term is the sum or difference of two products.
    localparam int TERM_W   = PROD_W + 1;
    // The accumulator update is done exactly in this width before clamping.
    localparam int SUM_W    = ((ACC_W > TERM_W) ? ACC_W : TERM_W) + 1;

    // Quarter-turn phase roll applied to the second transmit antenna's gain.
    typedef enum logic [1:0] {
        ROLL_0   = 2'd0,
        ROLL_90  = 2'd1,
        ROLL_180 = 2'd2,
        ROLL_270 = 2'd3
    } roll_t;

    // One receive antenna's sample with both channel gains.
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] rx_i;
        logic signed [SAMPLE_W-1:0] rx_q;
        logic signed [SAMPLE_W-1:0] chan1_i;
        logic signed [SAMPLE_W-1:0] chan1_q;
        logic signed [SAMPLE_W-1:0] chan2_i;
        logic signed [SAMPLE_W-1:0] chan2_q;
        roll_t                      roll_index;
        logic                       last_antenna;
    } prc_in_t;

    // Combined symbol and its QPSK decisions.
    typedef struct packed {
        logic signed [ACC_W-1:0] combined_i;
        logic signed [ACC_W-1:0] combined_q;
        logic                    bit_i;
        logic                    bit_q;
    } prc_out_t;

    // Control that travels with the registered products.
    typedef struct packed {
        logic valid;
        logic last;
    } prc_stage_t;

endpackage

>>> rtl/core/prc_mult.sv
module prc_mult
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  prc_pkg::prc_in_t                    in_data,
    input  logic                                prod_take,
    output prc_pkg::prc_stage_t                 prod_ctl,
    output logic signed [prc_pkg::PROD_W-1:0]   prod_ii,
    output logic signed [prc_pkg::PROD_W-1:0]   prod_qq,
    output logic signed [prc_pkg::PROD_W-1:0]   prod_iq,
    output logic signed [prc_pkg::PROD_W-1:0]   prod_qi
);
    import prc_pkg::*;

    logic                       in_valid_reg;
    logic                       in_valid_next;
    prc_in_t                    in_data_reg;
    logic                       prod_valid_reg;
    logic                       prod_valid_next;
    logic                       prod_last_reg;
    logic signed [PROD_W-1:0]   prod_ii_reg;
    logic signed [PROD_W-1:0]   prod_qq_reg;
    logic signed [PROD_W-1:0]   prod_iq_reg;
    logic signed [PROD_W-1:0]   prod_qi_reg;
    logic                       prod_free;
    logic                       prod_load;
    logic signed [WEIGHT_W-1:0] chan2_a;
    logic signed [WEIGHT_W-1:0] chan2_b;
    logic signed [WEIGHT_W-1:0] roll_i;
    logic signed [WEIGHT_W-1:0] roll_q;
    logic signed [WEIGHT_W-1:0] weight_i;
    logic signed [WEIGHT_W-1:0] weight_q;

    // Each register moves on when the one after it is empty or emptying.
    assign prod_free       = !prod_valid_reg || prod_take;
    assign in_ready        = !in_valid_reg || prod_free;
    assign prod_load       = prod_free && in_valid_reg;
    assign in_valid_next   = in_ready ? in_valid : in_valid_reg;
    assign prod_valid_next = prod_free ? in_valid_reg : prod_valid_reg;

    // Rotate conj(h2) by the roll index: only swaps and negations.
    assign chan2_a = WEIGHT_W'(in_data_reg.chan2_i);
    assign chan2_b = WEIGHT_W'(in_data_reg.chan2_q);

    always_comb
    begin
        unique case (in_data_reg.roll_index)
            ROLL_0:
            begin
                roll_i = chan2_a;
                roll_q = -chan2_b;
            end
            ROLL_90:
            begin
                roll_i = -chan2_b;
                roll_q = -chan2_a;
            end
            ROLL_180:
            begin
                roll_i = -chan2_a;
                roll_q = chan2_b;
            end
            ROLL_270:
            begin
                roll_i = chan2_b;
                roll_q = chan2_a;
            end
            default:
            begin
                roll_i = chan2_a;
                roll_q = -chan2_b;
            end
        endcase
    end

    // Weight c = conj(h1) + rotated conj(h2); the guard bits keep it exact.
    assign weight_i = WEIGHT_W'(in_data_reg.chan1_i) + roll_i;
    assign weight_q = roll_q - WEIGHT_W'(in_data_reg.chan1_q);

    // Valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            prod_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg   <= in_valid_next;
            prod_valid_reg <= prod_valid_next;
        end
    end

    // Input register and the four partial products of y * c.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_data_reg <= in_data;
        end
        if (prod_load)
        begin
            prod_last_reg <= in_data_reg.last_antenna;
            prod_ii_reg   <= PROD_W'(in_data_reg.rx_i) * PROD_W'(weight_i);
            prod_qq_reg   <= PROD_W'(in_data_reg.rx_q) * PROD_W'(weight_q);
            prod_iq_reg   <= PROD_W'(in_data_reg.rx_i) * PROD_W'(weight_q);
            prod_qi_reg   <= PROD_W'(in_data_reg.rx_q) * PROD_W'(weight_i);
        end
    end

    assign prod_ctl = '{valid: prod_valid_reg, last: prod_last_reg};
    assign prod_ii  = prod_ii_reg;
    assign prod_qq  = prod_qq_reg;
    assign prod_iq  = prod_iq_reg;
    assign prod_qi  = prod_qi_reg;

endmodule

>>> rtl/core/prc_accum.sv
module prc_accum
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  prc_pkg::prc_stage_t                 prod_ctl,
    input  logic signed [prc_pkg::PROD_W-1:0]   prod_ii,
    input  logic signed [prc_pkg::PROD_W-1:0]   prod_qq,
    input  logic signed [prc_pkg::PROD_W-1:0]   prod_iq,
    input  logic signed [prc_pkg::PROD_W-1:0]   prod_qi,
    output logic                                prod_take,
    output logic                                out_valid,
    input  logic                                out_ready,
    output prc_pkg::prc_out_t                   out_data
);
    import prc_pkg::*;

    logic signed [ACC_W-1:0]  sum_i_reg;
    logic signed [ACC_W-1:0]  sum_i_next;
    logic signed [ACC_W-1:0]  sum_q_reg;
    logic signed [ACC_W-1:0]  sum_q_next;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    prc_out_t                 out_data_reg;
    logic                     out_free;
    logic                     emit;
    logic signed [TERM_W-1:0] term_i;
    logic signed [TERM_W-1:0] term_q;
    logic signed [SUM_W-1:0]  total_i;
    logic signed [SUM_W-1:0]  total_q;
    logic signed [ACC_W-1:0]  sat_i;
    logic signed [ACC_W-1:0]  sat_q;

    // A last-antenna transaction needs room in the result register.
    assign out_free  = !out_valid_reg || out_ready;
    assign prod_take = prod_ctl.valid && (!prod_ctl.last || out_free);
    assign emit      = prod_take && prod_ctl.last;

    // Complex product z = y * c from the registered partial products.
    assign term_i = TERM_W'(prod_ii) - TERM_W'(prod_qq);
    assign term_q = TERM_W'(prod_iq) + TERM_W'(prod_qi);

    // Exact sum, then clamp to the accumulator range.
    assign total_i = SUM_W'(sum_i_reg) + SUM_W'(term_i);
    assign total_q = SUM_W'(sum_q_reg) + SUM_W'(term_q);

    always_comb
    begin
        if (total_i[SUM_W-1:ACC_W-1] == '0 || total_i[SUM_W-1:ACC_W-1] == '1)
        begin
            sat_i = total_i[ACC_W-1:0];
        end
        else
        begin
            sat_i = {total_i[SUM_W-1], {(ACC_W-1){~total_i[SUM_W-1]}}};
        end

        if (total_q[SUM_W-1:ACC_W-1] == '0 || total_q[SUM_W-1:ACC_W-1] == '1)
        begin
            sat_q = total_q[ACC_W-1:0];
        end
        else
        begin
            sat_q = {total_q[SUM_W-1], {(ACC_W-1){~total_q[SUM_W-1]}}};
        end
    end

    // Accumulators clear once the symbol has been handed to the result register.
    always_comb
    begin
        sum_i_next = sum_i_reg;
        sum_q_next = sum_q_reg;
        if (prod_take)
        begin
            if (prod_ctl.last)
            begin
                sum_i_next = '0;
                sum_q_next = '0;
            end
            else
            begin
                sum_i_next = sat_i;
                sum_q_next = sat_q;
            end
        end
    end

    // Result register holds until the transaction is taken downstream.
    always_comb
    begin
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_i_reg     <= '0;
            sum_q_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sum_i_reg     <= sum_i_next;
            sum_q_reg     <= sum_q_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Combined values and sign decisions; zero decides as 0.
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_data_reg.combined_i <= sat_i;
            out_data_reg.combined_q <= sat_q;
            out_data_reg.bit_i      <= !sat_i[ACC_W-1] && (sat_i != '0);
            out_data_reg.bit_q      <= !sat_q[ACC_W-1] && (sat_q != '0);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

>>> rtl/core/phase_roll_diversity_combiner.sv
// Receive combiner for two-antenna phase-roll transmit diversity with QPSK. Each
// transaction on the input carries one receive antenna's Q2.13 sample, the gains from
// both transmit antennas and the roll index; the block weights the sample by
// conj(h1) + conj(h2) rotated by a quarter turn per roll step, and accumulates the
// exact product into saturating Q13.26 sums. A transaction marked last antenna
// produces one output transaction with both sums and their sign decisions (1 only
// for a strictly positive sum) and clears the sums. One transaction is accepted per
// clock while in_ready is high; a transaction passes the input register, then the
// product register, then the accumulator and result register.
// A waiting result stalls the input only when a further last-antenna transaction
// arrives behind it.
module phase_roll_diversity_combiner
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  prc_pkg::prc_in_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output prc_pkg::prc_out_t out_data
);
    import prc_pkg::*;

    prc_stage_t               prod_ctl;
    logic                     prod_take;
    logic signed [PROD_W-1:0] prod_ii;
    logic signed [PROD_W-1:0] prod_qq;
    logic signed [PROD_W-1:0] prod_iq;
    logic signed [PROD_W-1:0] prod_qi;

    // Weight formation and complex multiply.
    prc_mult u_mult
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .prod_take (prod_take),
        .prod_ctl  (prod_ctl),
        .prod_ii   (prod_ii),
        .prod_qq   (prod_qq),
        .prod_iq   (prod_iq),
        .prod_qi   (prod_qi)
    );

    // Saturating accumulation and result register.
    prc_accum u_accum
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .prod_ctl  (prod_ctl),
        .prod_ii   (prod_ii),
        .prod_qq   (prod_qq),
        .prod_iq   (prod_iq),
        .prod_qi   (prod_qi),
        .prod_take (prod_take),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import prc_pkg::*;

    // Tracks the combining sums for each transaction on the input and checks each symbol
    // that leaves the block against the oldest one still owed.
    class symbol_scoreboard;

        prc_out_t expected_symbols[$];
        longint   accum_i;
        longint   accum_q;
        int       mismatches;
        int       symbols_checked;

        function new();
            accum_i = 0;
            accum_q = 0;
            mismatches = 0;
            symbols_checked = 0;
        endfunction

        // Clamp an exact sum to the accumulator range.
        function longint clamp_acc(input longint value);
            longint hi;
            longint lo;
            hi = (longint'(1) <<< (ACC_W - 1)) - 1;
            lo = -hi - 1;
            if (value > hi)
                return hi;
            if (value < lo)
                return lo;
            return value;
        endfunction

        // Weight one antenna's sample, add it to the sums and emit a symbol on the last one.
        function void absorb_antenna(input prc_in_t item);
            longint   yi, yq, h1i, h1q, a, b;
            longint   ti, tq, ci, cq, zi, zq;
            prc_out_t symbol;
            yi  = longint'($signed(item.rx_i));
            yq  = longint'($signed(item.rx_q));
            h1i = longint'($signed(item.chan1_i));
            h1q = longint'($signed(item.chan1_q));
            a   = longint'($signed(item.chan2_i));
            b   = longint'($signed(item.chan2_q));

            // Quarter turn of conj(h2) selected by the roll index.
            case (item.roll_index)
                ROLL_0:   begin ti = a;  tq = -b; end
                ROLL_90:  begin ti = -b; tq = -a; end
                ROLL_180: begin ti = -a; tq = b;  end
                default:  begin ti = b;  tq = a;  end
            endcase
            ci = h1i + ti;
            cq = -h1q + tq;

            // Exact complex product y * c; both fit easily in 64 bits.
            zi = yi * ci - yq * cq;
            zq = yi * cq + yq * ci;
            accum_i = clamp_acc(accum_i + zi);
            accum_q = clamp_acc(accum_q + zq);

            if (item.last_antenna)
            begin
                symbol.combined_i = accum_i[ACC_W-1:0];
                symbol.combined_q = accum_q[ACC_W-1:0];
                symbol.bit_i      = (accum_i > 0);
                symbol.bit_q      = (accum_q > 0);
                expected_symbols.push_back(symbol);
                accum_i = 0;
                accum_q = 0;
            end
        endfunction

        // Compare one output transaction with the oldest owed symbol.
        function void check_symbol(input prc_out_t actual);
            prc_out_t want;
            symbols_checked++;
            if (expected_symbols.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("[%0t] unexpected symbol: combined_i=%0d combined_q=%0d",
                             $realtime, actual.combined_i, actual.combined_q);
                return;
            end
            want = expected_symbols.pop_front();
            if (actual.combined_i !== want.combined_i || actual.combined_q !== want.combined_q
                || actual.bit_i !== want.bit_i || actual.bit_q !== want.bit_q)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("[%0t] symbol %0d mismatch: i %0d/%0d q %0d/%0d bits %b%b/%b%b",
                             $realtime, symbols_checked, want.combined_i, actual.combined_i,
                             want.combined_q, actual.combined_q, want.bit_i, want.bit_q,
                             actual.bit_i, actual.bit_q);
            end
        endfunction

        function int pending();
            return expected_symbols.size();
        endfunction

    endclass

    localparam int  RANDOM_ITEMS = 1300;
    localparam int  CYCLE_LIMIT  = 400000;
    localparam int  STALL_CYCLES = 400;
    localparam logic signed [SAMPLE_W-1:0] S_MAX = 16'sh7fff;
    localparam logic signed [SAMPLE_W-1:0] S_MIN = 16'sh8000;

    logic     clk;
    logic     rst_n;
    logic     in_valid;
    logic     in_ready;
    prc_in_t  in_data;
    logic     out_valid;
    logic     out_ready;
    prc_out_t out_data;

    symbol_scoreboard sb;
    int cycles;
    int items_sent;
    bit stall_done;

    phase_roll_diversity_combiner dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // Free-running 10 ns clock.
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Random idle length: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(5, 40);
    endfunction

    // Sample value biased toward the extremes and small values.
    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 11))
            0:       return S_MAX;
            1:       return S_MIN;
            2:       return '0;
            3:       return -16'sd1;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    function automatic prc_in_t antenna(input logic signed [SAMPLE_W-1:0] yi, yq, h1i, h1q,
                                        input logic signed [SAMPLE_W-1:0] a, b,
                                        input roll_t k, input logic last);
        prc_in_t item;
        item.rx_i         = yi;
        item.rx_q         = yq;
        item.chan1_i      = h1i;
        item.chan1_q      = h1q;
        item.chan2_i      = a;
        item.chan2_q      = b;
        item.roll_index   = k;
        item.last_antenna = last;
        return item;
    endfunction

    function automatic prc_in_t random_antenna(input logic last);
        return antenna(pick_sample(), pick_sample(), pick_sample(), pick_sample(),
                       pick_sample(), pick_sample(), roll_t'($urandom_range(0, 3)), last);
    endfunction

    // Offer one transaction, hold it until accepted, then idle at random.
    task automatic drive_antenna(input prc_in_t item);
        int gap;
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        items_sent++;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // A long run of worst-case terms of one sign, enough to drive a sum into its clamp,
    // followed by a few ordinary antennas that keep adding to the clamped value.
    task automatic drive_saturating_symbol(input bit toward_negative);
        int       len;
        int       n;
        prc_in_t  item;
        len = $urandom_range(135, 200);
        for (n = 0; n < len; n++)
        begin
            if (toward_negative)
                item = antenna(S_MAX, S_MAX, S_MIN, S_MAX, S_MAX, S_MIN, ROLL_180, 1'b0);
            else
                item = antenna(S_MIN, S_MAX, S_MIN, S_MAX, S_MAX, S_MIN, ROLL_180, 1'b0);
            drive_antenna(item);
        end
        for (n = $urandom_range(0, 3); n > 0; n--)
            drive_antenna(random_antenna(1'b0));
        drive_antenna(random_antenna(1'b1));
    endtask

    // Input monitor feeds the predictor; output monitor checks each symbol.
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            sb.absorb_antenna(in_data);
        if (rst_n && out_valid && out_ready)
            sb.check_symbol(out_data);
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Receiver: random ready pattern, with one long hold-off so the input backs up.
    initial
    begin
        int len;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!stall_done && sb.symbols_checked >= 30)
            begin
                out_ready <= 1'b0;
                repeat (STALL_CYCLES - 1) @(posedge clk);
                stall_done = 1'b1;
            end
            else
            begin
                len = pick_gap() + 1;
                out_ready <= ($urandom_range(0, 3) != 0);
                repeat (len - 1) @(posedge clk);
            end
        end
    end

    // Sender: reset, directed cases, random symbols, then drain.
    initial
    begin
        int     ants;
        int     k;
        roll_t  roll;
        bit     pos_burst_done;
        bit     neg_burst_done;

        sb = new();
        cycles = 0;
        items_sent = 0;
        stall_done = 1'b0;
        pos_burst_done = 1'b0;
        neg_burst_done = 1'b0;
        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_data  = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Single antennas at the extremes, every roll step.
        for (k = 0; k < 4; k++)
        begin
            roll = roll_t'(k);
            drive_antenna(antenna(S_MAX, S_MAX, S_MAX, S_MAX, S_MAX, S_MAX, roll, 1'b1));
            drive_antenna(antenna(S_MIN, S_MIN, S_MIN, S_MIN, S_MIN, S_MIN, roll, 1'b1));
            drive_antenna(antenna(S_MAX, S_MIN, S_MIN, S_MAX, S_MAX, S_MIN, roll, 1'b1));
        end
        // Zero sums give zero decisions.
        drive_antenna(antenna('0, '0, '0, '0, '0, '0, ROLL_0, 1'b1));
        drive_antenna(antenna(S_MAX, '0, '0, '0, '0, '0, ROLL_90, 1'b1));
        // Weight whose real part cancels: the rolled h2 negates only the real part of h1.
        drive_antenna(antenna(S_MAX, S_MAX, 16'sd100, 16'sd200, -16'sd100, 16'sd200,
                              ROLL_0, 1'b1));
        // Multi-antenna symbols, with accumulation across different roll steps.
        drive_antenna(antenna(16'sd8192, -16'sd8192, 16'sd4096, 16'sd1, 16'sd7, -16'sd3,
                              ROLL_90, 1'b0));
        drive_antenna(antenna(-16'sd8192, 16'sd8191, S_MIN, S_MAX, 16'sd12, 16'sd99,
                              ROLL_270, 1'b1));
        drive_antenna(random_antenna(1'b0));
        drive_antenna(random_antenna(1'b0));
        drive_antenna(random_antenna(1'b0));
        drive_antenna(random_antenna(1'b1));
        drive_antenna(random_antenna(1'b1));

        // Random symbols of a few antennas, with saturating runs in between.
        items_sent = 0;
        while (items_sent < RANDOM_ITEMS)
        begin
            if (!pos_burst_done && items_sent >= 300)
            begin
                drive_saturating_symbol(1'b0);
                pos_burst_done = 1'b1;
            end
            else if (!neg_burst_done && items_sent >= 750)
            begin
                drive_saturating_symbol(1'b1);
                neg_burst_done = 1'b1;
            end
            else
            begin
                ants = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 12)
                                                   : $urandom_range(1, 4);
                for (k = 1; k < ants; k++)
                    drive_antenna(random_antenna(1'b0));
                drive_antenna(random_antenna(1'b1));
            end
        end
        in_valid <= 1'b0;

        // Drain every owed symbol, then let the pipeline settle.
        while (sb.pending() > 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/prc_pkg.sv
rtl/core/prc_mult.sv
rtl/core/prc_accum.sv
rtl/core/phase_roll_diversity_combiner.sv
verif/testbench.sv
